// ===== design/amc_pkg.sv =====
// Shared definitions for the accumulator machine core: field widths, request and
// opcode codes, and the result record that travels to the output queue.
// No dependencies; imported by every other design file.
package amc_pkg;

    localparam int WORD_W         = 16;
    localparam int LADDR_W        = 12;
    localparam int REQ_W          = 2;
    localparam int OPC_W          = 4;
    localparam int PC_OUT_W       = 12;
    localparam int CNT_W          = 32;

    localparam int CODE_DEPTH_DEF = 4096;
    localparam int DATA_DEPTH_DEF = 4096;

    // Output queue sizing. The count also has to hold the queue depth plus the
    // two pipeline stages that may still push into it.
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH) + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CODE = 2'd0,
        REQ_DATA = 2'd1,
        REQ_EXEC = 2'd2
    } t_req;

    typedef enum logic [OPC_W-1:0] {
        OP_HLT = 4'd0,
        OP_IN  = 4'd1,
        OP_OUT = 4'd2,
        OP_LDA = 4'd3,
        OP_STA = 4'd4,
        OP_ADD = 4'd5,
        OP_SUB = 4'd6,
        OP_INC = 4'd7,
        OP_DEC = 4'd8,
        OP_JMP = 4'd9,
        OP_JZ  = 4'd10,
        OP_JN  = 4'd11,
        OP_LIT = 4'd12
    } t_opcode;

    typedef struct packed {
        logic                     out_valid;
        logic signed [WORD_W-1:0] out_value;
        logic                     in_taken;
        logic                     halted;
        logic [PC_OUT_W-1:0]      prog_counter;
        logic [CNT_W-1:0]         cycle_count;
    } t_result;

endpackage

// ===== design/amc_result_fifo.sv =====
// Small result queue between the execution pipeline and the output channel.
// Depends on amc_pkg for the result record and the queue sizing constants.
module amc_result_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  amc_pkg::t_result             i_push_data,
    output logic [amc_pkg::RES_CNT_W-1:0] o_count,
    output logic                         o_valid,
    input  logic                         i_ready,
    output amc_pkg::t_result             o_data
);
    import amc_pkg::*;

    t_result              r_slot [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + RES_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_count <= r_count + RES_CNT_W'(i_push) - RES_CNT_W'(pop);
        end
    end

    // The core only accepts an item when the queue has room reserved for it.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == RES_CNT_W'(RES_FIFO_DEPTH))))
        else $error("result queue pushed while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_W'(RES_FIFO_DEPTH))
        else $error("result queue count out of range");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) || (r_wr_ptr == r_rd_ptr))
        else $error("result queue empty but pointers differ");

endmodule

// ===== design/accumulator_machine_core.sv =====
// Accumulator machine core: a three-stage pipeline around a dual-read code store and
// a one-read, one-write data store, both synchronous memories. Depends on amc_pkg and
// amc_result_fifo.
//
// Each accepted item yields exactly one result, in order. Code and data word
// writes can stream at one per cycle unless an execute request or a full result
// queue holds the input side. After an execute request on a running machine the next
// item waits: the opcode and operand are read from the code store in the accept
// cycle, and the next program counter is only known in the following cycle, once that
// registered read data is decoded. A data-store update (STA writes, INC and DEC
// read and write back) finishes in stage 2 while the next item can already be taken.
// The input side also waits when the four-entry result queue has no room for what is
// in flight. After reset the block sweeps both stores to zero, one address per cycle,
// over the larger of the two depths, and accepts no item during that sweep. Both
// depths must be powers of two, so addresses wrap by dropping upper bits.
module accumulator_machine_core #(
    parameter int CODE_DEPTH = amc_pkg::CODE_DEPTH_DEF,
    parameter int DATA_DEPTH = amc_pkg::DATA_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [amc_pkg::REQ_W-1:0]          i_req_type,
    input  logic [amc_pkg::LADDR_W-1:0]        i_load_addr,
    input  logic signed [amc_pkg::WORD_W-1:0]  i_load_value,
    input  logic signed [amc_pkg::WORD_W-1:0]  i_in_value,

    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_out_valid,
    output logic signed [amc_pkg::WORD_W-1:0]  o_out_value,
    output logic                               o_in_taken,
    output logic                               o_halted,
    output logic [amc_pkg::PC_OUT_W-1:0]       o_prog_counter,
    output logic [amc_pkg::CNT_W-1:0]          o_cycle_count
);
    import amc_pkg::*;

    localparam int CODE_AW   = $clog2(CODE_DEPTH);
    localparam int DATA_AW   = $clog2(DATA_DEPTH);
    localparam int CLR_DEPTH = (CODE_DEPTH > DATA_DEPTH) ? CODE_DEPTH : DATA_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    // Stores.
    logic [WORD_W-1:0]  r_code_mem [CODE_DEPTH];
    logic [WORD_W-1:0]  r_data_mem [DATA_DEPTH];

    // Architectural state.
    logic [CODE_AW-1:0] r_pc;
    logic [WORD_W-1:0]  r_acc;
    logic               r_halt;
    logic [CNT_W-1:0]   r_cnt;

    // Clearing sweep.
    logic               r_clr_busy;
    logic [CLR_AW-1:0]  r_clr_idx;

    // Input side.
    logic               accept;
    t_req               req;
    logic [WORD_W-1:0]  ld_ext;
    logic [CODE_AW-1:0] ld_code_a;
    logic [DATA_AW-1:0] ld_data_a;
    logic [CODE_AW-1:0] pc_plus1;

    // Stage 1: code read data present.
    logic               r_s1_v;
    logic               r_s1_run;
    t_req               r_s1_req;
    logic [DATA_AW-1:0] r_s1_laddr;
    logic [WORD_W-1:0]  r_s1_lval;
    logic [WORD_W-1:0]  r_s1_ival;
    logic [WORD_W-1:0]  r_op_q;
    logic [WORD_W-1:0]  r_arg_q;
    logic               op_known;
    t_opcode            s1_op;
    logic               s1_halt;
    logic [CODE_AW-1:0] pc_seq;
    logic [CODE_AW-1:0] jmp_tgt;
    logic [CODE_AW-1:0] n_pc;
    logic [CNT_W-1:0]   n_cnt;
    logic [DATA_AW-1:0] s1_raddr;

    // Stage 2: data read data present.
    logic               r_s2_v;
    logic               r_s2_run;
    t_req               r_s2_req;
    t_opcode            r_s2_op;
    logic [DATA_AW-1:0] r_s2_daddr;
    logic [WORD_W-1:0]  r_s2_imm;
    logic [WORD_W-1:0]  r_s2_ival;
    logic [WORD_W-1:0]  r_data_q;
    logic               r_fwd_hit;
    logic [WORD_W-1:0]  r_fwd_data;
    logic [WORD_W-1:0]  data_val;
    logic               dwe;
    logic [WORD_W-1:0]  dwd;
    logic [WORD_W-1:0]  n_acc;
    logic [WORD_W-1:0]  pc_ext;
    t_result            res;

    // Output queue.
    logic [RES_CNT_W-1:0] fifo_cnt;
    logic [RES_CNT_W-1:0] inflight;
    t_result              res_head;

    // ------------------------------------------------------------------
    // Input handshake
    // ------------------------------------------------------------------
    assign inflight = fifo_cnt + RES_CNT_W'(r_s1_v) + RES_CNT_W'(r_s2_v);

    // An executing item in stage 1 still has to produce the next program counter.
    assign o_ready = !r_clr_busy && !(r_s1_v && r_s1_run)
                     && (inflight < RES_CNT_W'(RES_FIFO_DEPTH));
    assign accept  = i_valid && o_ready;

    assign req       = t_req'(i_req_type);
    assign ld_ext    = WORD_W'(i_load_addr);
    assign ld_code_a = ld_ext[CODE_AW-1:0];
    assign ld_data_a = ld_ext[DATA_AW-1:0];
    assign pc_plus1  = r_pc + CODE_AW'(1);

    // ------------------------------------------------------------------
    // Code store: cleared, written by code word transfers, read at pc and pc+1
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_code_mem[r_clr_idx[CODE_AW-1:0]] <= '0;
        end else if (accept && (req == REQ_CODE)) begin
            r_code_mem[ld_code_a] <= i_load_value;
        end
        if (accept) begin
            r_op_q  <= r_code_mem[r_pc];
            r_arg_q <= r_code_mem[pc_plus1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode, next program counter, data read address
    // ------------------------------------------------------------------
    assign op_known = (r_op_q <= WORD_W'(OP_LIT));
    assign pc_seq   = r_pc + CODE_AW'(2);
    assign jmp_tgt  = r_arg_q[CODE_AW-1:0];
    assign s1_raddr = r_arg_q[DATA_AW-1:0];
    assign n_cnt    = (&r_cnt) ? r_cnt : r_cnt + CNT_W'(1);

    always_comb begin
        s1_op   = op_known ? t_opcode'(r_op_q[OPC_W-1:0]) : OP_HLT;
        s1_halt = 1'b0;
        n_pc    = pc_seq;
        case (s1_op)
            OP_HLT: begin
                n_pc    = r_pc;
                s1_halt = 1'b1;
            end
            OP_JMP: begin
                n_pc = jmp_tgt;
            end
            OP_JZ: begin
                if (r_acc == '0) begin
                    n_pc = jmp_tgt;
                end
            end
            OP_JN: begin
                if (r_acc[WORD_W-1]) begin
                    n_pc = jmp_tgt;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: data read-modify-write, accumulator update, result
    // ------------------------------------------------------------------
    // A data word write in stage 2 can hit the address that stage 1 is reading.
    assign data_val = r_fwd_hit ? r_fwd_data : r_data_q;

    always_comb begin
        dwe   = 1'b0;
        dwd   = r_s2_imm;
        n_acc = r_acc;
        if (r_s2_v && r_s2_run) begin
            case (r_s2_op)
                OP_IN:  n_acc = r_s2_ival;
                OP_LDA: n_acc = data_val;
                OP_STA: begin
                    dwe = 1'b1;
                    dwd = r_acc;
                end
                OP_ADD: n_acc = r_acc + data_val;
                OP_SUB: n_acc = r_acc - data_val;
                OP_INC: begin
                    dwe = 1'b1;
                    dwd = data_val + WORD_W'(1);
                end
                OP_DEC: begin
                    dwe = 1'b1;
                    dwd = data_val - WORD_W'(1);
                end
                OP_LIT: n_acc = r_s2_imm;
                default: begin
                end
            endcase
        end else if (r_s2_v && (r_s2_req == REQ_DATA)) begin
            dwe = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_data_mem[r_clr_idx[DATA_AW-1:0]] <= '0;
        end else if (dwe) begin
            r_data_mem[r_s2_daddr] <= dwd;
        end
        r_data_q   <= r_data_mem[s1_raddr];
        r_fwd_hit  <= dwe && (r_s2_daddr == s1_raddr);
        r_fwd_data <= dwd;
    end

    assign pc_ext = WORD_W'(r_pc);

    always_comb begin
        res.out_valid    = r_s2_run && (r_s2_op == OP_OUT);
        res.out_value    = res.out_valid ? r_acc : '0;
        res.in_taken     = r_s2_run && (r_s2_op == OP_IN);
        res.halted       = r_halt;
        res.prog_counter = pc_ext[PC_OUT_W-1:0];
        res.cycle_count  = r_cnt;
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req   <= req;
            r_s1_run   <= (req == REQ_EXEC) && !r_halt;
            r_s1_laddr <= ld_data_a;
            r_s1_lval  <= i_load_value;
            r_s1_ival  <= i_in_value;
        end
        if (r_s1_v) begin
            r_s2_req   <= r_s1_req;
            r_s2_run   <= r_s1_run;
            r_s2_op    <= s1_op;
            r_s2_daddr <= r_s1_run ? s1_raddr : r_s1_laddr;
            r_s2_imm   <= r_s1_run ? r_arg_q : r_s1_lval;
            r_s2_ival  <= r_s1_ival;
        end
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_pc       <= '0;
            r_acc      <= '0;
            r_halt     <= 1'b0;
            r_cnt      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            if (r_s1_v && r_s1_run) begin
                r_pc  <= n_pc;
                r_cnt <= n_cnt;
                if (s1_halt) begin
                    r_halt <= 1'b1;
                end
            end
            if (r_s2_v && r_s2_run) begin
                r_acc <= n_acc;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + CLR_AW'(1);
                if (r_clr_idx == CLR_AW'(CLR_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    amc_result_fifo u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s2_v),
        .i_push_data (res),
        .o_count     (fifo_cnt),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (res_head)
    );

    assign o_out_valid    = res_head.out_valid;
    assign o_out_value    = res_head.out_value;
    assign o_in_taken     = res_head.in_taken;
    assign o_halted       = res_head.halted;
    assign o_prog_counter = res_head.prog_counter;
    assign o_cycle_count  = res_head.cycle_count;

    // Two executing items never sit in stage 1 on consecutive cycles.
    a_exec_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_run) |=> !(r_s1_v && r_s1_run))
        else $error("back-to-back execute in decode stage");

    // The executed count moves only when an instruction is decoded.
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_v && r_s1_run) |=> (r_cnt == $past(r_cnt)))
        else $error("executed count changed without an instruction");

    // Only reset leaves the halted state.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

endmodule

// ===== sim/amc_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the accumulator machine core testbench: a behavioral copy of the
// machine state and a queue of the results each transfer should produce.
// Depends on amc_pkg for field widths, codes and the result record.
package amc_tb_pkg;

    import amc_pkg::*;

    localparam int CODE_AW = $clog2(CODE_DEPTH_DEF);
    localparam int DATA_AW = $clog2(DATA_DEPTH_DEF);

    class amc_tracker;

        bit [WORD_W-1:0]  code_words [CODE_DEPTH_DEF];
        bit [WORD_W-1:0]  data_words [DATA_DEPTH_DEF];
        bit [WORD_W-1:0]  acc;
        bit [CODE_AW-1:0] pc;
        bit               halt;
        bit [CNT_W-1:0]   exec_count;
        t_result          step_results [$];
        int               errors;
        int               results_seen;

        // Applies one accepted request to the machine state and queues its result.
        function void note_request(logic [REQ_W-1:0] req, logic [LADDR_W-1:0] addr,
                                   logic [WORD_W-1:0] lval, logic [WORD_W-1:0] ival);
            t_result          r;
            t_opcode          op;
            bit [WORD_W-1:0]  opw;
            bit [WORD_W-1:0]  arg;
            bit [CODE_AW-1:0] next_pc;
            bit [CODE_AW-1:0] jump_pc;
            bit [DATA_AW-1:0] da;
            r = '0;
            case (req)
                REQ_CODE: code_words[CODE_AW'(addr)] = lval;
                REQ_DATA: data_words[DATA_AW'(addr)] = lval;
                REQ_EXEC: begin
                    if (!halt) begin
                        opw     = code_words[pc];
                        next_pc = pc + 1'b1;
                        arg     = code_words[next_pc];
                        next_pc = pc + 2'd2;
                        jump_pc = CODE_AW'(arg);
                        da      = DATA_AW'(arg);
                        op      = t_opcode'(opw[OPC_W-1:0]);
                        if (exec_count != '1) begin
                            exec_count++;
                        end
                        // Any word above the last opcode stops the machine like HLT.
                        if (opw > 16'(OP_LIT)) begin
                            halt = 1'b1;
                        end else begin
                            case (op)
                                OP_IN: begin
                                    acc = ival;
                                    r.in_taken = 1'b1;
                                    pc = next_pc;
                                end
                                OP_OUT: begin
                                    r.out_valid = 1'b1;
                                    r.out_value = acc;
                                    pc = next_pc;
                                end
                                OP_LDA: begin
                                    acc = data_words[da];
                                    pc = next_pc;
                                end
                                OP_STA: begin
                                    data_words[da] = acc;
                                    pc = next_pc;
                                end
                                OP_ADD: begin
                                    acc = acc + data_words[da];
                                    pc = next_pc;
                                end
                                OP_SUB: begin
                                    acc = acc - data_words[da];
                                    pc = next_pc;
                                end
                                OP_INC: begin
                                    data_words[da] = data_words[da] + 1'b1;
                                    pc = next_pc;
                                end
                                OP_DEC: begin
                                    data_words[da] = data_words[da] - 1'b1;
                                    pc = next_pc;
                                end
                                OP_JMP: pc = jump_pc;
                                OP_JZ:  pc = (acc == '0) ? jump_pc : next_pc;
                                OP_JN:  pc = acc[WORD_W-1] ? jump_pc : next_pc;
                                OP_LIT: begin
                                    acc = arg;
                                    pc = next_pc;
                                end
                                default: halt = 1'b1;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
            r.halted       = halt;
            r.prog_counter = PC_OUT_W'(pc);
            r.cycle_count  = exec_count;
            step_results.push_back(r);
        endfunction

        function int outstanding();
            return step_results.size();
        endfunction

        task report_mismatch(string field, logic [63:0] seen, logic [63:0] want);
            $display("mismatch in %s at result %0d: got %0h, expected %0h",
                     field, results_seen, seen, want);
            errors++;
        endtask

        task check_result(t_result seen);
            t_result want;
            results_seen++;
            if (step_results.size() == 0) begin
                report_mismatch("result with no request waiting", 0, 0);
                return;
            end
            want = step_results.pop_front();
            if (seen.out_valid !== want.out_valid)
                report_mismatch("out_valid", seen.out_valid, want.out_valid);
            if (seen.out_value !== want.out_value)
                report_mismatch("out_value", $unsigned(seen.out_value),
                                $unsigned(want.out_value));
            if (seen.in_taken !== want.in_taken)
                report_mismatch("in_taken", seen.in_taken, want.in_taken);
            if (seen.halted !== want.halted)
                report_mismatch("halted", seen.halted, want.halted);
            if (seen.prog_counter !== want.prog_counter)
                report_mismatch("prog_counter", seen.prog_counter, want.prog_counter);
            if (seen.cycle_count !== want.cycle_count)
                report_mismatch("cycle_count", seen.cycle_count, want.cycle_count);
        endtask

    endclass

endpackage

// ===== sim/accumulator_machine_core_test.sv =====
`timescale 1ns / 1ps
// Top-level testbench for accumulator_machine_core: loads small looping programs,
// steps them with random stalls on both sides and checks every result in order.
// Depends on amc_pkg, amc_tb_pkg and the design files.
module accumulator_machine_core_test;

    import amc_pkg::*;
    import amc_tb_pkg::*;

    // The block sweeps both stores after reset and takes no transfer meanwhile, so
    // the limit on cycles without any transfer sits well above that sweep.
    localparam int STALL_LIMIT   = 12000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int ITEM_TARGET   = 1950;
    localparam int MAX_SLOTS     = 16;
    localparam logic [REQ_W-1:0]   REQ_UNUSED    = 2'd3;
    localparam logic [LADDR_W-1:0] DIRECTED_BASE = 12'hFFA;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [REQ_W-1:0]     i_req_type;
    logic [LADDR_W-1:0]   i_load_addr;
    logic [WORD_W-1:0]    i_load_value;
    logic [WORD_W-1:0]    i_in_value;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_out_valid;
    logic [WORD_W-1:0]    o_out_value;
    logic                 o_in_taken;
    logic                 o_halted;
    logic [PC_OUT_W-1:0]  o_prog_counter;
    logic [CNT_W-1:0]     o_cycle_count;

    amc_tracker           tracker;
    bit                   src_idle_en;
    bit                   sink_idle_en;
    int                   items_sent;
    int                   stall_cycles;
    int                   phase;
    logic [LADDR_W-1:0]   prog_base;
    int                   prog_slots;
    logic [LADDR_W-1:0]   busy_words [8];

    always #1 i_clk = ~i_clk;

    accumulator_machine_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_load_addr    (i_load_addr),
        .i_load_value   (i_load_value),
        .i_in_value     (i_in_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_valid    (o_out_valid),
        .o_out_value    (o_out_value),
        .o_in_taken     (o_in_taken),
        .o_halted       (o_halted),
        .o_prog_counter (o_prog_counter),
        .o_cycle_count  (o_cycle_count)
    );

    always @(posedge i_clk) begin
        i_ready <= !(sink_idle_en && $urandom_range(0, 99) < 31);
    end

    // Handshakes are sampled at the falling edge, where every signal is settled
    // and the transfer at the next rising edge is already decided.
    always @(negedge i_clk) begin : result_monitor
        t_result seen;
        if (o_valid === 1'b1 && i_ready === 1'b1) begin
            seen.out_valid    = o_out_valid;
            seen.out_value    = o_out_value;
            seen.in_taken     = o_in_taken;
            seen.halted       = o_halted;
            seen.prog_counter = o_prog_counter;
            seen.cycle_count  = o_cycle_count;
            tracker.check_result(seen);
        end
    end

    always @(negedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) ||
            (o_valid === 1'b1 && i_ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Valid stays high after a transfer; the next call either presents a new
    // request in the same step or first lowers valid while it idles.
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [LADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] lval, input logic [WORD_W-1:0] ival);
        while (src_idle_en && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_load_addr  <= addr;
        i_load_value <= lval;
        i_in_value   <= ival;
        do @(negedge i_clk); while (o_ready !== 1'b1);
        tracker.note_request(req, addr, lval, ival);
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic exec_step(input logic [WORD_W-1:0] ival);
        send_item(REQ_EXEC, LADDR_W'($urandom), WORD_W'($urandom), ival);
    endtask

    task automatic write_slot(input logic [LADDR_W-1:0] base, input int slot,
                              input logic [WORD_W-1:0] opw, input logic [WORD_W-1:0] arg);
        logic [LADDR_W-1:0] a;
        a = base + LADDR_W'(2 * slot);
        send_item(REQ_CODE, a, opw, WORD_W'($urandom));
        send_item(REQ_CODE, a + 1'b1, arg, WORD_W'($urandom));
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [LADDR_W-1:0] pick_data_addr();
        return ($urandom_range(0, 3) == 0) ? LADDR_W'($urandom)
                                          : busy_words[$urandom_range(0, 7)];
    endfunction

    // Jump targets always land on an instruction of the current program, so the
    // machine never runs into unwritten code and halts early.
    task automatic pick_instruction(output logic [WORD_W-1:0] opw,
                                    output logic [WORD_W-1:0] arg);
        t_opcode op;
        op  = t_opcode'($urandom_range(OP_IN, OP_LIT));
        opw = WORD_W'(op);
        case (op)
            OP_JMP, OP_JZ, OP_JN:
                arg = {4'($urandom),
                       prog_base + LADDR_W'(2 * $urandom_range(0, prog_slots - 1))};
            OP_LDA, OP_STA, OP_ADD, OP_SUB, OP_INC, OP_DEC:
                arg = {4'($urandom), pick_data_addr()};
            default:
                arg = WORD_W'($urandom);
        endcase
    endtask

    // The old program is overwritten with jumps to the new one, so the next
    // instruction leaves it wherever the program counter stands.
    task automatic load_program(input logic [LADDR_W-1:0] base, input int slots);
        logic [LADDR_W-1:0] old_base;
        int                 old_slots;
        logic [WORD_W-1:0]  opw;
        logic [WORD_W-1:0]  arg;
        old_base   = prog_base;
        old_slots  = prog_slots;
        prog_base  = base;
        prog_slots = slots;
        for (int i = 0; i < old_slots; i++) begin
            write_slot(old_base, i, WORD_W'(OP_JMP), {4'($urandom), base});
        end
        for (int i = 0; i < slots - 1; i++) begin
            pick_instruction(opw, arg);
            write_slot(base, i, opw, arg);
        end
        write_slot(base, slots - 1, WORD_W'(OP_JMP), {4'($urandom), base});
        for (int i = $urandom_range(0, 3); i > 0; i--) begin
            send_item(REQ_DATA, pick_data_addr(), WORD_W'($urandom), WORD_W'($urandom));
        end
    endtask

    task automatic run_program(input int steps);
        int                pick;
        logic [WORD_W-1:0] opw;
        logic [WORD_W-1:0] arg;
        for (int k = 0; k < steps; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                exec_step(WORD_W'($urandom));
            end else if (pick < 88) begin
                send_item(REQ_DATA, pick_data_addr(), WORD_W'($urandom), WORD_W'($urandom));
            end else if (pick < 93) begin
                // The closing jump is left alone so the program stays a loop.
                pick_instruction(opw, arg);
                write_slot(prog_base, $urandom_range(0, prog_slots - 2), opw, arg);
            end else if (pick < 98) begin
                send_item(REQ_CODE,
                          prog_base + LADDR_W'(2 * prog_slots) +
                          LADDR_W'($urandom_range(0, 4095 - 2 * prog_slots)),
                          WORD_W'($urandom), WORD_W'($urandom));
            end else begin
                send_item(REQ_UNUSED, LADDR_W'($urandom), WORD_W'($urandom),
                          WORD_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [LADDR_W-1:0] base;
        logic [WORD_W-1:0]  stop_word;
        tracker      = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req_type   <= REQ_CODE;
        i_load_addr  <= '0;
        i_load_value <= '0;
        i_in_value   <= '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        busy_words[0] = '0;
        busy_words[1] = '1;
        for (int i = 2; i < 8; i++) begin
            busy_words[i] = LADDR_W'($urandom);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed program: wraps across the top of the code store and holds every
        // non-halting opcode, extreme values and oversized operands; JZ is skipped.
        send_item(REQ_DATA, 12'h000, 16'h0001, 16'hFFFF);
        prog_base  = DIRECTED_BASE;
        prog_slots = 12;
        write_slot(DIRECTED_BASE, 0, WORD_W'(OP_LIT), 16'h7FFF);
        write_slot(DIRECTED_BASE, 1, WORD_W'(OP_ADD), 16'hF000);
        write_slot(DIRECTED_BASE, 2, WORD_W'(OP_JN), {4'hA, DIRECTED_BASE + 12'd8});
        write_slot(DIRECTED_BASE, 3, WORD_W'(OP_JZ), {4'h5, DIRECTED_BASE});
        write_slot(DIRECTED_BASE, 4, WORD_W'(OP_STA), 16'h0FFF);
        write_slot(DIRECTED_BASE, 5, WORD_W'(OP_IN), 16'hFFFF);
        write_slot(DIRECTED_BASE, 6, WORD_W'(OP_INC), 16'hFFFF);
        write_slot(DIRECTED_BASE, 7, WORD_W'(OP_DEC), 16'h0000);
        write_slot(DIRECTED_BASE, 8, WORD_W'(OP_SUB), 16'h0FFF);
        write_slot(DIRECTED_BASE, 9, WORD_W'(OP_OUT), 16'h0000);
        write_slot(DIRECTED_BASE, 10, WORD_W'(OP_LDA), 16'hF000);
        write_slot(DIRECTED_BASE, 11, WORD_W'(OP_JMP), {4'hF, DIRECTED_BASE});
        for (int i = 0; i < 12; i++) begin
            exec_step((i == 4) ? 16'h8000 : WORD_W'($urandom));
        end
        send_item(REQ_UNUSED, 12'hFFF, 16'hFFFF, 16'h7FFF);
        exec_step(16'h0000);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            src_idle_en  = !(phase >= 6 && phase < 10);
            sink_idle_en = src_idle_en;
            if (phase == 3 || $urandom_range(0, 7) == 0) begin
                wait_for_results();
            end
            if ($urandom_range(0, 3) == 0) begin
                base = 12'hFF0 + LADDR_W'(2 * $urandom_range(0, 7));
            end else begin
                base = LADDR_W'($urandom) & ~12'd1;
            end
            load_program(base, $urandom_range(2, MAX_SLOTS));
            run_program($urandom_range(5, 60));
            phase++;
        end

        // Stopping is permanent, so it comes last: plain HLT, an unknown low code,
        // or a word whose upper bits are set.
        case ($urandom_range(0, 2))
            0:       stop_word = WORD_W'(OP_HLT);
            1:       stop_word = WORD_W'($urandom_range(13, 15));
            default: stop_word = WORD_W'($urandom_range(16, 65535));
        endcase
        for (int i = 0; i < prog_slots; i++) begin
            write_slot(prog_base, i, stop_word, WORD_W'($urandom));
        end
        exec_step(WORD_W'($urandom));
        exec_step(WORD_W'($urandom));
        send_item(REQ_DATA, pick_data_addr(), WORD_W'($urandom), WORD_W'($urandom));
        send_item(REQ_CODE, prog_base, WORD_W'(OP_LIT), WORD_W'($urandom));
        send_item(REQ_UNUSED, LADDR_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
        exec_step(WORD_W'($urandom));

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/amc_pkg.sv
design/amc_result_fifo.sv
design/accumulator_machine_core.sv
sim/amc_tb_pkg.sv
sim/accumulator_machine_core_test.sv
